>>> src/pdme_pkg.sv
// ----------------------------------------------------------------------------
// pdme_pkg
// Shared sizes, item types and helpers for the page directory with
// most-recently-used replacement.
// ----------------------------------------------------------------------------
package pdme_pkg;

  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CapacityReset = CAP_W'(16);

  typedef struct packed {
    logic [15:0] tbl_id;
    logic [23:0] page_no;
  } pdme_req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evicted;
    logic [15:0] evicted_table;
    logic [23:0] evicted_page;
    logic        error;
  } pdme_rsp_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              free;
    logic [SLOT_W-1:0] free_idx;
  } pdme_match_t;

  function automatic logic [3:0] slot_field(logic [SLOT_W-1:0] idx);
    logic [SLOT_W+3:0] wide;
    wide = {4'b0000, idx};
    return wide[3:0];
  endfunction

endpackage

>>> src/pdme_match.sv
// ----------------------------------------------------------------------------
// pdme_match
// Parallel key compare over all slots with lowest-index priority, and a
// lowest-free-slot pick.
// ----------------------------------------------------------------------------
module pdme_match import pdme_pkg::*; (
  input  pdme_req_t         key_i,
  input  logic [SLOTS-1:0]  valid_i,
  input  logic [15:0]       tab_i [SLOTS],
  input  logic [23:0]       page_i [SLOTS],
  output pdme_match_t       match_o
);

  always_comb begin
    match_o = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid_i[i] && tab_i[i] == key_i.tbl_id && page_i[i] == key_i.page_no) begin
        match_o.hit     = 1'b1;
        match_o.hit_idx = SLOT_W'(i);
      end
      if (!valid_i[i]) begin
        match_o.free     = 1'b1;
        match_o.free_idx = SLOT_W'(i);
      end
    end
  end

endmodule

>>> src/pdme_dir.sv
// ----------------------------------------------------------------------------
// pdme_dir
// Directory store: valid bits, keys, most-recent pointer and occupancy.
// Decides hit, fill, evict or error for the registered item and updates state.
// ----------------------------------------------------------------------------
module pdme_dir import pdme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  pdme_req_t        req_i,
  input  logic [CAP_W-1:0] capacity_i,
  output pdme_rsp_t        rsp_o
);

  logic [SLOTS-1:0]  valid_q;
  logic [15:0]       tab_q [SLOTS];
  logic [23:0]       page_q [SLOTS];
  logic [SLOT_W-1:0] recent_q, recent_d;
  logic              recent_valid_q, recent_valid_d;
  logic [CNT_W-1:0]  occ_q, occ_d;

  pdme_match_t       match;
  logic [LIM_W-1:0]  cap_ext, limit;
  logic              at_cap, recent_ok;
  logic              wr_en, set_valid;
  logic [SLOT_W-1:0] wr_idx;

  pdme_match u_match (
    .key_i   (req_i),
    .valid_i (valid_q),
    .tab_i   (tab_q),
    .page_i  (page_q),
    .match_o (match)
  );

  assign cap_ext   = LIM_W'(capacity_i);
  assign limit     = (cap_ext < LIM_W'(SLOTS)) ? cap_ext : LIM_W'(SLOTS);
  assign at_cap    = LIM_W'(occ_q) >= limit;
  assign recent_ok = recent_valid_q && (32'(recent_q) < SLOTS) && valid_q[recent_q];

  always_comb begin
    rsp_o          = '0;
    wr_en          = 1'b0;
    set_valid      = 1'b0;
    wr_idx         = recent_q;
    recent_d       = recent_q;
    recent_valid_d = recent_valid_q;
    occ_d          = occ_q;
    if (match.hit) begin
      rsp_o.hit      = 1'b1;
      rsp_o.slot     = slot_field(match.hit_idx);
      recent_d       = match.hit_idx;
      recent_valid_d = 1'b1;
    end else if (at_cap) begin
      if (recent_ok) begin
        rsp_o.slot          = slot_field(recent_q);
        rsp_o.evicted       = 1'b1;
        rsp_o.evicted_table = tab_q[recent_q];
        rsp_o.evicted_page  = page_q[recent_q];
        wr_en               = 1'b1;
      end else begin
        rsp_o.error = 1'b1;
      end
    end else if (match.free) begin
      rsp_o.slot     = slot_field(match.free_idx);
      wr_en          = 1'b1;
      set_valid      = 1'b1;
      wr_idx         = match.free_idx;
      recent_d       = match.free_idx;
      recent_valid_d = 1'b1;
      occ_d          = occ_q + CNT_W'(1);
    end else begin
      rsp_o.error = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= '0;
      recent_q       <= '0;
      recent_valid_q <= 1'b0;
      occ_q          <= '0;
    end else if (req_valid_i) begin
      if (set_valid) begin
        valid_q[wr_idx] <= 1'b1;
      end
      recent_q       <= recent_d;
      recent_valid_q <= recent_valid_d;
      occ_q          <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && wr_en) begin
      tab_q[wr_idx]  <= req_i.tbl_id;
      page_q[wr_idx] <= req_i.page_no;
    end
  end

endmodule

>>> src/page_directory_mru_evict.sv
// ----------------------------------------------------------------------------
// page_directory_mru_evict
// Fully associative page directory with most-recently-used replacement.
//
//   channel   signals                     direction  handshake
//   request   start, busy, req_i          in         start & !busy
//   result    done_o, rsp_o               out        done_o, one cycle
//   config    cfg_we_i, cfg_wdata_i       in         cfg_we_i
//
// One item per cycle: an accepted item is registered, looked up against all
// slots and resolved in the following cycle, and its result appears on rsp_o
// with done_o in the cycle after that.
// busy is always low; the slot compare and free pick set the cycle.
// Reset clears all valid bits, the recent pointer and occupancy; capacity
// returns to 16. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module page_directory_mru_evict import pdme_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pdme_req_t        req_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i,
  output logic             done_o,
  output pdme_rsp_t        rsp_o
);

  logic             req_valid_q;
  pdme_req_t        req_q;
  logic [CAP_W-1:0] capacity_q;
  logic             done_q;
  pdme_rsp_t        rsp_q, rsp_d;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      done_q      <= 1'b0;
      capacity_q  <= CapacityReset;
    end else begin
      req_valid_q <= start && !busy;
      done_q      <= req_valid_q;
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      req_q <= req_i;
    end
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  pdme_dir u_dir (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_q),
    .req_i       (req_q),
    .capacity_i  (capacity_q),
    .rsp_o       (rsp_d)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule
